### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the LRU key-value cache.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define LKV_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");

// Consequent that must hold at the next clock edge after the antecedent.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`else

`define LKV_ASSERT_ALWAYS(label, clk, rst, prop)
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/lkv_pkg.sv
// Package of the LRU key-value cache: sizes, codes and shared types.
// No dependencies; used by the interfaces, the cell and the top level.
package lkv_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int KEY_BITS      = 16;
   localparam int VALUE_BITS    = 31;
   localparam int CAP_BITS      = 5;
   localparam int IDX_BITS      = $clog2(MAX_ENTRIES);
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic                    OP_GET       = 1'b0;
   localparam logic                    OP_PUT       = 1'b1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CAP_BITS-1:0]      CAP_RESET    = CAP_BITS'(MAX_ENTRIES);

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // Broadcast to every cell for the transfer being taken this cycle.
   typedef struct packed {
      logic                hit;
      logic                fill;
      logic                evict;
      logic [KEY_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

### rtl/lkv_req_if.sv
// Request channel of the LRU key-value cache: valid/ready plus payload.
// Depends on lkv_pkg for the field widths.
interface lkv_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [lkv_pkg::KEY_BITS-1:0]    key;
   logic [lkv_pkg::VALUE_BITS-1:0]  value;

   modport source (output valid, operation, key, value, input ready);
   modport sink   (input valid, operation, key, value, output ready);
endinterface

### rtl/lkv_rsp_if.sv
// Response channel of the LRU key-value cache: valid/ready plus payload.
// Depends on lkv_pkg for the field widths.
interface lkv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [lkv_pkg::VALUE_BITS-1:0]  read_value;

   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

### rtl/lkv_cell.sv
// One recency-ordered storage cell of the LRU key-value cache.
// Depends on lkv_pkg for the entry and control types.
module lkv_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lkv_pkg::cell_ctrl_type ctrl,
   input  lkv_pkg::entry_type     left_entry,
   input  logic                   move_in,
   input  logic                   right_valid,
   output lkv_pkg::entry_type     entry,
   output logic                   valid,
   output logic                   match,
   output logic                   move_out
);

   lkv_pkg::entry_type entry_ff, entry_in;
   logic               valid_ff, valid_in;
   logic               terminal;

   assign match = valid_ff && (entry_ff.key == ctrl.key);

   // The shift down the row stops at the matched cell, at the first free cell,
   // or at the least recent cell when it is evicted.
   assign terminal = (ctrl.hit && match)
                   || (ctrl.fill && !valid_ff)
                   || (ctrl.evict && valid_ff && !right_valid);
   assign move_out = move_in && !terminal;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (move_in) begin
         entry_in = left_entry;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

### rtl/lru_key_value_cache_unit.sv
// LRU key-value cache top level: a row of cells kept in recency order.
// Latency: a response appears in the cycle after its request transfer.
// Throughput: one request per cycle unless a held response is refused; the whole cell row updates together.
// Reset (synchronous, active high) empties every cell and sets capacity to 16.
// Depends on lkv_pkg, lkv_req_if, lkv_rsp_if, lkv_cell and assert_macros.svh.
`include "assert_macros.svh"

module lru_key_value_cache_unit (
   input  logic                               clock,
   input  logic                               reset,
   lkv_req_if.sink                            req,
   lkv_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lkv_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lkv_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lkv_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam int N = lkv_pkg::MAX_ENTRIES;

   // Cell 0 holds the most recent entry and cell N-1 the least recent one.
   // The valid cells always form an unbroken run from cell 0, so the number
   // of entries in use is simply the length of that run.

   logic [lkv_pkg::CAP_BITS-1:0]   cap_ff, cap_in;
   logic [lkv_pkg::IDX_BITS-1:0]   cap_last;
   logic                           csr_write;

   lkv_pkg::entry_type             cell_entry [N];
   logic [N-1:0]                   cell_valid;
   logic [N-1:0]                   cell_match;
   logic [N:0]                     move;
   lkv_pkg::entry_type             new_entry;
   lkv_pkg::cell_ctrl_type         ctrl;

   logic                           accept;
   logic                           is_put;
   logic                           any_hit;
   logic                           full;
   logic [lkv_pkg::VALUE_BITS-1:0] hit_value;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [lkv_pkg::VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;

   // Configuration port. Only the capacity register exists; it is written at
   // the access phase of a write transfer and reads back as stored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cap_in = cap_ff;
      if (csr_write && (csr_paddr == lkv_pkg::CSR_CAPACITY)) begin
         cap_in = csr_pwdata[lkv_pkg::CAP_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == lkv_pkg::CSR_CAPACITY) begin
         csr_prdata = lkv_pkg::CSR_DATA_BITS'(cap_ff);
      end
   end

   // Index of the last cell the cache may fill. A capacity of zero behaves as
   // one, and anything beyond the row length saturates to the row length.
   always_comb begin
      if (cap_ff == '0) begin
         cap_last = '0;
      end else if (cap_ff > lkv_pkg::CAP_BITS'(N)) begin
         cap_last = lkv_pkg::IDX_BITS'(N - 1);
      end else begin
         cap_last = lkv_pkg::IDX_BITS'(cap_ff - 1'b1);
      end
   end

   // The response register parts the two sides: a new request is taken while
   // the previous response is being taken or once it has gone.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign is_put    = (req.operation == lkv_pkg::OP_PUT);

   // Keys are unique in the row, so at most one cell matches and a plain OR
   // picks out the stored value.
   assign any_hit = |cell_match;

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < N; i++) begin
         if (cell_match[i]) begin
            hit_value = hit_value | cell_entry[i].value;
         end
      end
   end

   // While fewer entries than the capacity are in use, the cell at the
   // capacity limit is still free and a put miss fills; otherwise it evicts
   // the least recent valid entry, even when the capacity has been lowered
   // below the number of entries already held.
   assign full = cell_valid[cap_last];

   assign ctrl.hit   = accept && any_hit;
   assign ctrl.fill  = accept && is_put && !any_hit && !full;
   assign ctrl.evict = accept && is_put && !any_hit && full;
   assign ctrl.key   = req.key;

   // Whatever becomes most recent enters at cell 0: the request's key with the
   // new value on a put, or the matched entry unchanged on a get hit.
   assign new_entry.key   = req.key;
   assign new_entry.value = is_put ? req.value : hit_value;

   assign move[0] = ctrl.hit || ctrl.fill || ctrl.evict;

   for (genvar g = 0; g < N; g++) begin : g_cell
      lkv_pkg::entry_type left_entry;
      logic               right_valid;

      if (g == 0) begin : g_head
         assign left_entry = new_entry;
      end else begin : g_body
         assign left_entry = cell_entry[g-1];
      end

      if (g == N - 1) begin : g_tail
         assign right_valid = 1'b0;
      end else begin : g_next
         assign right_valid = cell_valid[g+1];
      end

      lkv_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .move_in     (move[g]),
         .right_valid (right_valid),
         .entry       (cell_entry[g]),
         .valid       (cell_valid[g]),
         .match       (cell_match[g]),
         .move_out    (move[g+1])
      );
   end

   // Response register. The value is returned only on a get hit.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = any_hit;
         rsp_value_in = (!is_put && any_hit) ? hit_value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lkv_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.read_value = rsp_value_ff;

   // Valid cells stay a contiguous run starting at cell 0.
   `LKV_ASSERT_ALWAYS(a_valid_prefix, clock, reset, ((cell_valid >> 1) & ~cell_valid) == '0)
   // A key is never held by two cells.
   `LKV_ASSERT_ALWAYS(a_single_match, clock, reset, $onehot0(cell_match))
   // Entries are never dropped, so the occupied run never shrinks.
   `LKV_ASSERT_NEXT(a_no_shrink, clock, reset, 1'b1, $countones(cell_valid) >= $past($countones(cell_valid)))
   // Every request transfer leaves a pending response behind it.
   `LKV_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid_ff)

endmodule

### tb/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the LRU key-value cache: randomised gets and puts
// against an in-bench recency model. Depends on lkv_pkg, lkv_req_if, lkv_rsp_if
// and the top level lru_key_value_cache_unit.
module lru_key_value_cache_unit_tb;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned POOL_SIZE   = 24;
   // The long receiver hold-off starts once this many requests have been taken,
   // which falls in the middle of the first long random phase.
   localparam int unsigned HOLD_AT     = 150;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned MAX_MISMATCH_REPORTS = 10;

   typedef struct {
      logic                           op;
      logic [lkv_pkg::KEY_BITS-1:0]   key;
      logic [lkv_pkg::VALUE_BITS-1:0] value;
      int unsigned                    gap;
   } cache_request_type;

   typedef struct {
      logic                           hit;
      logic [lkv_pkg::VALUE_BITS-1:0] read_value;
   } access_result_type;

   logic clock;
   logic reset;

   lkv_req_if req_if ();
   lkv_rsp_if rsp_if ();

   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [lkv_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [lkv_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [lkv_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   lru_key_value_cache_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Requests waiting to be offered, and the results expected back in order.
   cache_request_type pending_requests[$];
   access_result_type expected_results[$];

   int unsigned items_queued;
   int unsigned items_accepted;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // Transfers seen at the last rising edge, read by the drivers at the falling edge.
   logic req_taken;
   logic rsp_taken;

   // When set, neither side idles: back-to-back transfers at full rate.
   logic steady_flow;

   logic [lkv_pkg::KEY_BITS-1:0] key_pool[POOL_SIZE];

   // Model of the cache contents. Recency rank 0 is the most recently used slot.
   logic                           slot_valid[lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::KEY_BITS-1:0]   slot_key[lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::VALUE_BITS-1:0] slot_value[lkv_pkg::MAX_ENTRIES];
   int unsigned                    slot_rank[lkv_pkg::MAX_ENTRIES];
   int unsigned                    slots_filled;
   logic [lkv_pkg::CAP_BITS-1:0]   cap_setting;

   function automatic void record_mismatch(input string what, input logic [63:0] want,
                                           input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_MISMATCH_REPORTS)
         $display("mismatch in %s: expected %0h, actual %0h", what, want, got);
   endfunction

   // Moves slot s to the front. If s held an entry, only the slots that were more
   // recent than it age; a slot being filled for the first time ages every valid slot.
   function automatic void make_most_recent(input int s, input logic was_valid);
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         if (i != s && slot_valid[i] && (!was_valid || slot_rank[i] < slot_rank[s]))
            slot_rank[i]++;
      end
      slot_rank[s] = 0;
   endfunction

   // Applies one request to the model and returns the result the cache should give.
   function automatic access_result_type predict_access(input cache_request_type item);
      access_result_type outcome;
      int unsigned       limit;
      int                match;
      int                slot;
      // A capacity of zero behaves as one; anything beyond the slot count saturates.
      if (cap_setting == 0)
         limit = 1;
      else if (cap_setting > lkv_pkg::MAX_ENTRIES)
         limit = lkv_pkg::MAX_ENTRIES;
      else
         limit = 32'(cap_setting);
      match = -1;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         if (match < 0 && slot_valid[i] && slot_key[i] == item.key)
            match = i;
      end
      outcome.hit        = (match >= 0);
      outcome.read_value = '0;
      if (match >= 0) begin
         if (item.op == lkv_pkg::OP_GET)
            outcome.read_value = slot_value[match];
         else
            slot_value[match] = item.value;
         make_most_recent(match, 1'b1);
      end else if (item.op == lkv_pkg::OP_PUT) begin
         slot = -1;
         if (slots_filled < limit) begin
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
               if (slot < 0 && !slot_valid[i])
                  slot = i;
            end
         end
         if (slot >= 0) begin
            slots_filled++;
            slot_key[slot]   = item.key;
            slot_value[slot] = item.value;
            make_most_recent(slot, 1'b0);
            slot_valid[slot] = 1'b1;
         end else begin
            // No room under the current capacity: replace the least recent entry,
            // including when the capacity was lowered below the slots already filled.
            slot = 0;
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
               if (slot_valid[i] && (!slot_valid[slot] || slot_rank[i] > slot_rank[slot]))
                  slot = i;
            end
            slot_key[slot]   = item.key;
            slot_value[slot] = item.value;
            make_most_recent(slot, 1'b1);
         end
      end
      return outcome;
   endfunction

   // Clock: 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a run that stalls is a failure.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[lru_key_value_cache_unit] ERROR");
         $finish;
      end
   end

   // Monitor: samples both channels at the rising edge. A request transfer is fed
   // to the model straight away; a response transfer is checked against the oldest
   // expectation. The push comes first so that a same-cycle answer would also match.
   always @(posedge clock) begin : monitor
      access_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         rsp_taken <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(predict_access('{req_if.operation, req_if.key,
                                                         req_if.value, 0}));
            items_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               record_mismatch("response with nothing expected", '0,
                               64'({rsp_if.hit, rsp_if.read_value}));
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.hit !== want.hit)
                  record_mismatch("hit", 64'(want.hit), 64'(rsp_if.hit));
               if (rsp_if.read_value !== want.read_value)
                  record_mismatch("read_value", 64'(want.read_value),
                                  64'(rsp_if.read_value));
            end
         end
      end
   end

   // Request driver: changes inputs at the falling edge. An offered request is held
   // until its transfer; the next one is offered after its own drawn gap.
   always @(negedge clock) begin : request_driver
      cache_request_type head;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_requests.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (pending_requests[0].gap > 0) begin
            req_if.valid <= 1'b0;
            pending_requests[0].gap = pending_requests[0].gap - 1;
         end else begin
            head = pending_requests.pop_front();
            req_if.valid     <= 1'b1;
            req_if.operation <= head.op;
            req_if.key       <= head.key;
            req_if.value     <= head.value;
         end
      end
   end

   // Response receiver: after each transfer it draws a random stall, which may be none.
   // Once, part way through a long random phase, it holds ready low for a long
   // stretch so that the cache backs up and refuses requests.
   always @(negedge clock) begin : response_receiver
      int unsigned stall_left;
      int unsigned hold_left;
      logic        hold_done;
      int unsigned draw;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (!hold_done && items_accepted >= HOLD_AT) begin
         rsp_if.ready <= 1'b0;
         hold_left = LONG_HOLD - 1;
         hold_done = 1'b1;
      end else if (rsp_taken) begin
         draw = steady_flow ? 0 : $urandom_range(0, 7);
         rsp_if.ready <= (draw == 0);
         stall_left = (draw == 0) ? 0 : draw - 1;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic queue_request(input logic op, input logic [lkv_pkg::KEY_BITS-1:0] key,
                                input logic [lkv_pkg::VALUE_BITS-1:0] value);
      pending_requests.push_back('{op, key, value,
                                   steady_flow ? 0 : $urandom_range(0, 7)});
      items_queued++;
   endtask

   // Random traffic: keys mostly from the first span entries of the pool, so that
   // hits, updates and evictions are frequent, with a share of arbitrary keys.
   task automatic queue_random(input int unsigned count, input int unsigned span);
      logic [lkv_pkg::KEY_BITS-1:0] key;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, span - 1)];
         else
            key = lkv_pkg::KEY_BITS'($urandom);
         queue_request($urandom_range(0, 1) ? lkv_pkg::OP_PUT : lkv_pkg::OP_GET, key,
                       lkv_pkg::VALUE_BITS'($urandom));
      end
   endtask

   // Holds the sender back until every request has had its response.
   task automatic wait_drained();
      while (items_accepted != items_queued || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Writes the capacity register, then reads it back. Only called while idle.
   task automatic write_capacity(input logic [lkv_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= lkv_pkg::CSR_CAPACITY;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cap_setting = data[lkv_pkg::CAP_BITS-1:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== lkv_pkg::CSR_DATA_BITS'(cap_setting))
         record_mismatch("capacity read-back", 64'(cap_setting), 64'(csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Main sequence: reset, a short directed part, then random phases under
   // several capacity settings, each phase draining before the next write.
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = lkv_pkg::OP_GET;
      req_if.key       = '0;
      req_if.value     = '0;
      rsp_if.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = lkv_pkg::CSR_CAPACITY;
      csr_pwdata       = '0;
      steady_flow      = 1'b0;
      items_queued     = 0;
      items_accepted   = 0;
      mismatch_count   = 0;
      slots_filled     = 0;
      cap_setting      = lkv_pkg::CAP_RESET;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_rank[i]  = 0;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = lkv_pkg::KEY_BITS'($urandom);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset capacity: a get on the empty cache, fills with extreme keys and
      // values, a put that updates an existing key, and a miss among hits.
      queue_request(lkv_pkg::OP_GET, 16'h0000, '0);
      queue_request(lkv_pkg::OP_PUT, 16'h0000, '1);
      queue_request(lkv_pkg::OP_PUT, 16'hFFFF, '0);
      queue_request(lkv_pkg::OP_GET, 16'h0000, '0);
      queue_request(lkv_pkg::OP_GET, 16'hFFFF, '1);
      queue_request(lkv_pkg::OP_PUT, 16'h0000, 31'd5);
      queue_request(lkv_pkg::OP_GET, 16'h0000, '0);
      queue_request(lkv_pkg::OP_GET, 16'h1234, '0);
      queue_request(lkv_pkg::OP_GET, 16'hFFFF, '0);
      wait_drained();

      // Capacity zero behaves as one, and already lies below the two filled
      // slots: every put miss replaces the least recent entry.
      write_capacity('0);
      queue_request(lkv_pkg::OP_PUT, 16'h00AA, 31'd1);
      queue_request(lkv_pkg::OP_GET, 16'h00AA, '0);
      queue_request(lkv_pkg::OP_PUT, 16'h00BB, 31'd2);
      queue_request(lkv_pkg::OP_GET, 16'h00AA, '0);
      queue_request(lkv_pkg::OP_GET, 16'h00BB, '0);
      wait_drained();

      // An oversized write saturates at the slot count; alternating bit patterns.
      write_capacity('1);
      queue_request(lkv_pkg::OP_PUT, 16'h5555, 31'h2AAA_AAAA);
      queue_request(lkv_pkg::OP_PUT, 16'hAAAA, 31'h5555_5555);
      queue_request(lkv_pkg::OP_GET, 16'h5555, '0);
      queue_request(lkv_pkg::OP_GET, 16'hAAAA, '0);
      queue_request(lkv_pkg::OP_GET, 16'h00BB, '0);
      wait_drained();

      // Full capacity with more keys than slots; the long receiver hold-off
      // happens during this phase while the sender keeps offering requests.
      queue_random(180, POOL_SIZE);
      wait_drained();

      // Capacity lowered below the slots already filled.
      write_capacity(32'd3);
      queue_random(100, 6);
      wait_drained();

      // Capacity one with the upper data bits set, run at full rate.
      steady_flow = 1'b1;
      write_capacity(32'hFFFF_FFE1);
      queue_random(40, 3);
      wait_drained();
      steady_flow = 1'b0;

      write_capacity(32'd16);
      queue_random(100, POOL_SIZE);
      wait_drained();

      write_capacity(32'd17);
      queue_random(60, 20);
      wait_drained();

      // Responses follow in the cycle after their request; the final wait catches
      // a stray response that turns up late.
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[lru_key_value_cache_unit] OK");
      end else begin
         $display("[lru_key_value_cache_unit] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_req_if.sv
rtl/lkv_rsp_if.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_unit.sv
tb/lru_key_value_cache_unit_tb.sv
